>>> rtl/iss_pkg.sv
// Shared constants and types for the indexed sequence store.
package iss_pkg;

  // Number of cells in the chain
  localparam int CAPACITY = 64;

  // Field widths fixed by the stream format
  localparam int OP_W  = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 7;

  // Count must hold CAPACITY itself; compares run at the wider of count and position
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Hit gather: cells are ORed in groups, group results registered
  localparam int GRP_SZ = 8;
  localparam int NGRP   = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

  // Stream widths, padded to whole bytes
  localparam int IN_BITS  = OP_W + POS_W + VAL_W;
  localparam int OUT_BITS = ST_W + VAL_W + LEN_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Request codes
  localparam logic [OP_W-1:0] OP_INS = 2'd0;
  localparam logic [OP_W-1:0] OP_EXT = 2'd1;
  localparam logic [OP_W-1:0] OP_APP = 2'd2;
  localparam logic [OP_W-1:0] OP_REM = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             ext;
    logic [CMP_W-1:0] pos;
  } iss_cmd_t;

endpackage

>>> rtl/iss_cell.sv
// One storage cell of the chain: holds one value and shifts with its neighbors.
module iss_cell (
  input  logic                        clk,
  input  iss_pkg::iss_cmd_t           cmd,
  input  logic [iss_pkg::CMP_W-1:0]   cell_idx,
  input  logic [iss_pkg::VAL_W-1:0]   new_val,
  input  logic [iss_pkg::VAL_W-1:0]   prev_val,
  input  logic [iss_pkg::VAL_W-1:0]   next_val,
  output logic [iss_pkg::VAL_W-1:0]   val,
  output logic [iss_pkg::VAL_W-1:0]   hit
);

  logic [iss_pkg::VAL_W-1:0] val_r;
  logic [iss_pkg::VAL_W-1:0] val_nxt;
  logic                      at_pos;
  logic                      past_pos;

  assign at_pos   = (cell_idx == cmd.pos);
  assign past_pos = (cell_idx > cmd.pos);

  // Insert: open a gap at the position; extract: close it from above
  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (at_pos) begin
        val_nxt = new_val;
      end else if (past_pos) begin
        val_nxt = prev_val;
      end
    end else if (cmd.ext) begin
      if (at_pos || past_pos) begin
        val_nxt = next_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  // Value leaving the chain, zero everywhere else
  assign hit = (cmd.ext && at_pos) ? val_r : '0;

endmodule

>>> rtl/iss_gather.sv
// Collects the one extracted value from the cells through a registered OR tree.
module iss_gather (
  input  logic                      clk,
  input  logic                      load,
  input  logic [iss_pkg::VAL_W-1:0] hits [iss_pkg::CAPACITY],
  output logic [iss_pkg::VAL_W-1:0] value
);

  logic [iss_pkg::VAL_W-1:0] grp_r   [iss_pkg::NGRP];
  logic [iss_pkg::VAL_W-1:0] grp_nxt [iss_pkg::NGRP];

  // First level: OR within each group
  always_comb begin
    for (int g = 0; g < iss_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < iss_pkg::GRP_SZ; k++) begin
        if (g * iss_pkg::GRP_SZ + k < iss_pkg::CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | hits[g * iss_pkg::GRP_SZ + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_nxt;
    end
  end

  // Second level: OR of the group results
  always_comb begin
    value = '0;
    for (int g = 0; g < iss_pkg::NGRP; g++) begin
      value = value | grp_r[g];
    end
  end

endmodule

>>> rtl/indexed_sequence_store_top.sv
// Top level of the indexed sequence store: request decode, cell chain and result stage.
// Holds an ordered sequence of up to CAPACITY (64) signed 32-bit values in a chain of
// cells. Each request inserts at a position, extracts at a position, appends at the tail
// or removes the tail, and returns one result with a status, the removed value (zero
// unless a value was taken out) and the new length. On acceptance every cell compares
// its index with the position and shifts at once while the leaving value is captured
// in grouped OR registers and the status and length enter the result stage; the groups
// are combined into the output register when it is free or being read. The next request
// is accepted as soon as the previous one has moved into the output register, even
// while that result still waits.
// No clearing pass after reset; the store is ready as soon as reset is released.
module indexed_sequence_store_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // in_tdata: op[1:0], position[8:2], value[40:9], zero fill above
  input  logic [iss_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // out_tdata: status[1:0], removed_value[33:2], length[40:34], zero fill above
  output logic [iss_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready
);

  // Input fields
  logic [iss_pkg::OP_W-1:0]  in_op;
  logic [iss_pkg::POS_W-1:0] in_position;
  logic [iss_pkg::VAL_W-1:0] in_value;

  assign in_op       = in_tdata[iss_pkg::OP_W-1:0];
  assign in_position = in_tdata[iss_pkg::OP_W +: iss_pkg::POS_W];
  assign in_value    = in_tdata[iss_pkg::OP_W + iss_pkg::POS_W +: iss_pkg::VAL_W];

  // Element count
  logic [iss_pkg::CNT_W-1:0] count_r;
  logic [iss_pkg::CNT_W-1:0] count_nxt;

  // Decode stage
  logic                      accept;
  iss_pkg::iss_cmd_t         cmd;
  logic [iss_pkg::ST_W-1:0]  status;
  logic [iss_pkg::CMP_W-1:0] pos_x;
  logic [iss_pkg::CMP_W-1:0] cnt_x;
  logic                      full;
  logic                      empty;

  // Result stage between chain and output register
  logic                      st_valid_r;
  logic [iss_pkg::ST_W-1:0]  st_status_r;
  logic [iss_pkg::LEN_W-1:0] st_len_r;
  logic                      advance;
  logic [iss_pkg::VAL_W-1:0] removed;

  // Output register
  logic                      out_valid_r;
  logic [iss_pkg::ST_W-1:0]  out_status_r;
  logic [iss_pkg::VAL_W-1:0] out_removed_r;
  logic [iss_pkg::LEN_W-1:0] out_len_r;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !st_valid_r;

  assign pos_x = iss_pkg::CMP_W'(in_position);
  assign cnt_x = iss_pkg::CMP_W'(count_r);
  assign full  = (count_r == iss_pkg::CNT_W'(iss_pkg::CAPACITY));
  assign empty = (count_r == '0);

  // Request decode: status and the command for the cells
  always_comb begin
    cmd.ins = 1'b0;
    cmd.ext = 1'b0;
    cmd.pos = pos_x;
    status  = iss_pkg::ST_OK;
    case (in_op)
      iss_pkg::OP_INS: begin
        if (pos_x > cnt_x) begin
          status = iss_pkg::ST_BADPOS;
        end else if (full) begin
          status = iss_pkg::ST_FULL;
        end else begin
          cmd.ins = accept;
        end
      end
      iss_pkg::OP_EXT: begin
        if (pos_x >= cnt_x) begin
          status = iss_pkg::ST_EMPTY;
        end else begin
          cmd.ext = accept;
        end
      end
      iss_pkg::OP_APP: begin
        cmd.pos = cnt_x;
        if (full) begin
          status = iss_pkg::ST_FULL;
        end else begin
          cmd.ins = accept;
        end
      end
      default: begin
        cmd.pos = cnt_x - iss_pkg::CMP_W'(1);
        if (empty) begin
          status = iss_pkg::ST_EMPTY;
        end else begin
          cmd.ext = accept;
        end
      end
    endcase
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + iss_pkg::CNT_W'(1);
    end else if (cmd.ext) begin
      count_nxt = count_r - iss_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Cell chain
  logic [iss_pkg::VAL_W-1:0] cell_val [iss_pkg::CAPACITY];
  logic [iss_pkg::VAL_W-1:0] cell_hit [iss_pkg::CAPACITY];

  for (genvar i = 0; i < iss_pkg::CAPACITY; i++) begin : g_cell
    logic [iss_pkg::VAL_W-1:0] prev_v;
    logic [iss_pkg::VAL_W-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = cell_val[i];
    end else begin : g_mid_lo
      assign prev_v = cell_val[i-1];
    end

    if (i == iss_pkg::CAPACITY - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_mid_hi
      assign next_v = cell_val[i+1];
    end

    iss_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .cell_idx (iss_pkg::CMP_W'(i)),
      .new_val  (in_value),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_val[i]),
      .hit      (cell_hit[i])
    );
  end

  // Extracted value gather, loaded with the request
  iss_gather u_gather (
    .clk   (clk),
    .load  (accept),
    .hits  (cell_hit),
    .value (removed)
  );

  assign advance = st_valid_r && (!out_valid_r || out_tready);

  // Result stage control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (accept) begin
      st_valid_r <= 1'b1;
    end else if (advance) begin
      st_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_status_r <= status;
      st_len_r    <= iss_pkg::LEN_W'(iss_pkg::CMP_W'(count_nxt));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r  <= st_status_r;
      out_removed_r <= removed;
      out_len_r     <= st_len_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = iss_pkg::OUT_W'({out_len_r, out_removed_r, out_status_r});

`ifndef SYNTHESIS
  // Count never runs past the number of cells
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= iss_pkg::CNT_W'(iss_pkg::CAPACITY))
    else $error("count exceeds capacity");

  // A granted insert grows the count by one
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + iss_pkg::CNT_W'(1))
    else $error("insert did not grow count");

  // A granted extract shrinks the count by one
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ext |=> count_r == $past(count_r) - iss_pkg::CNT_W'(1))
    else $error("extract did not shrink count");

  // A refused request leaves the count alone
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && status != iss_pkg::ST_OK |=> $stable(count_r))
    else $error("refused request changed count");
`endif

endmodule

>>> tb/iss_mirror_pkg.sv
// Mirror of the sequence store with the queue of awaited results.
package iss_mirror_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import iss_pkg::*;

  // One awaited result, split into its fields
  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] removed;
    logic [LEN_W-1:0]        length;
  } seq_result_t;

  class sequence_mirror;
    logic signed [VAL_W-1:0] cells [CAPACITY];
    int unsigned             fill;
    seq_result_t             awaited_results [$];
    int unsigned             errors;
    int unsigned             requests;
    int unsigned             checked;
    int unsigned             peak_fill;
    int unsigned             status_hits [4];

    function new();
      fill = 0;
      errors = 0;
      requests = 0;
      checked = 0;
      peak_fill = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // Open a slot at pos by moving the tail up one cell
    function void insert_at(int unsigned pos, logic signed [VAL_W-1:0] val);
      int unsigned i;
      for (i = fill; i > pos; i--) cells[i] = cells[i-1];
      cells[pos] = val;
      fill++;
    endfunction

    // Take the value at pos and close the gap
    function logic signed [VAL_W-1:0] take_at(int unsigned pos);
      logic signed [VAL_W-1:0] v;
      int unsigned i;
      v = cells[pos];
      for (i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
      fill--;
      return v;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
      seq_result_t r;
      r.status  = ST_OK;
      r.removed = '0;
      case (op)
        OP_INS: begin
          // bad position wins over full
          if (pos > fill) r.status = ST_BADPOS;
          else if (fill >= CAPACITY) r.status = ST_FULL;
          else insert_at(pos, val);
        end
        OP_EXT: begin
          if (pos >= fill) r.status = ST_EMPTY;
          else r.removed = take_at(pos);
        end
        OP_APP: begin
          if (fill >= CAPACITY) r.status = ST_FULL;
          else insert_at(fill, val);
        end
        default: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.removed = take_at(fill - 1);
        end
      endcase
      r.length = LEN_W'(fill);
      requests++;
      status_hits[r.status]++;
      if (fill > peak_fill) peak_fill = fill;
      awaited_results.push_back(r);
    endfunction

    // Compare one result transfer against the oldest awaited result
    function void check_result(logic [OUT_W-1:0] word);
      seq_result_t got;
      seq_result_t want;
      got.status  = word[ST_W-1:0];
      got.removed = word[ST_W +: VAL_W];
      got.length  = word[ST_W+VAL_W +: LEN_W];
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d removed %0d length %0d",
                 $time, got.status, got.removed, got.length);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.removed !== want.removed) begin
        $display("%0t: removed value mismatch: expected %0d actual %0d",
                 $time, want.removed, got.removed);
        errors++;
      end
      if (got.length !== want.length) begin
        $display("%0t: length mismatch: expected %0d actual %0d",
                 $time, want.length, got.length);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/testbench.sv
// Stream-level testbench for the indexed sequence store.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iss_pkg::*;
  import iss_mirror_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  sequence_mirror mirror = new();

  indexed_sequence_store_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #10 clk = ~clk;

  // Result side: check each transfer, then pick the next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one request, with random idle cycles ahead of it, and wait for the transfer
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-IN_BITS){1'b0}}, val, pos, op};
    do @(posedge clk); while (!in_tready);
    mirror.note_request(op, pos, val);
  endtask

  // Hold the input off until every awaited result has arrived
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (mirror.awaited_results.size() != 0) @(posedge clk);
  endtask

  // One random request; grow favors inserts and appends, otherwise removals
  task automatic random_request(input bit grow);
    int unsigned             roll;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    roll = $urandom_range(99);
    if (grow) op = (roll < 45) ? OP_INS : (roll < 80) ? OP_APP : (roll < 90) ? OP_EXT : OP_REM;
    else op = (roll < 10) ? OP_INS : (roll < 20) ? OP_APP : (roll < 65) ? OP_EXT : OP_REM;
    // mostly legal positions, some anywhere in the field
    if ($urandom_range(99) < 12) pos = POS_W'($urandom_range(127));
    else if (op == OP_INS) pos = POS_W'($urandom_range(mirror.fill));
    else if (op == OP_EXT && mirror.fill > 0) pos = POS_W'($urandom_range(mirror.fill - 1));
    else pos = POS_W'($urandom_range(127));
    roll = $urandom_range(99);
    case (roll)
      0: val = 32'sh8000_0000;
      1: val = 32'sh7FFF_FFFF;
      2: val = -32'sd1;
      3: val = '0;
      default: val = $urandom;
    endcase
    send_request(op, pos, val);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    bit          grow;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refusals on an empty store, then head, middle and tail traffic
    send_request(OP_REM, 7'd0,   32'sd0);
    send_request(OP_EXT, 7'd0,   32'sd0);
    send_request(OP_INS, 7'd1,   32'sd5);
    send_request(OP_INS, 7'd127, -32'sd1);
    send_request(OP_EXT, 7'd127, -32'sd1);
    send_request(OP_INS, 7'd0,   32'sh8000_0000);
    send_request(OP_APP, 7'd127, 32'sh7FFF_FFFF);
    send_request(OP_INS, 7'd2,   -32'sd1);
    send_request(OP_INS, 7'd1,   32'sd0);
    send_request(OP_INS, 7'd0,   32'sh5A5A_5A5A);
    send_request(OP_EXT, 7'd4,   32'sd0);
    send_request(OP_EXT, 7'd1,   -32'sd1);
    send_request(OP_EXT, 7'd3,   32'sd0);
    send_request(OP_EXT, 7'd0,   32'sd0);
    send_request(OP_REM, 7'd127, -32'sd1);
    send_request(OP_REM, 7'd0,   32'sd0);
    send_request(OP_REM, 7'd0,   32'sd0);
    send_request(OP_APP, 7'd0,   32'shA5A5_A5A5);
    send_request(OP_INS, 7'd0,   32'sd1);
    send_request(OP_INS, 7'd3,   32'sd2);
    send_request(OP_REM, 7'd0,   32'sd0);
    send_request(OP_EXT, 7'd0,   32'sd0);
    hold_until_drained();

    // Random phases with different idle and stall pressure
    grow = 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (n = 0; n < 232; n++) begin
        // switch between filling and emptying now and then
        if (n % 40 == 39 && $urandom_range(3) != 0) grow = ~grow;
        random_request(grow);
        if (n == 116) hold_until_drained();
      end
      hold_until_drained();
    end

    // Let any late result show up before closing
    repeat (10) @(posedge clk);

    $display("%0d requests sent, %0d results checked, peak fill %0d of %0d",
             mirror.requests, mirror.checked, mirror.peak_fill, CAPACITY);
    $display("statuses: ok %0d, empty/bad extract %0d, bad insert %0d, full %0d",
             mirror.status_hits[ST_OK], mirror.status_hits[ST_EMPTY],
             mirror.status_hits[ST_BADPOS], mirror.status_hits[ST_FULL]);
    if (mirror.errors == 0 && mirror.awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
